### design/subgraph_shape_classifier_core_macros.svh
// Assertion macros used by the checker file.
`ifndef SUBGRAPH_SHAPE_CLASSIFIER_CORE_MACROS_SVH
`define SUBGRAPH_SHAPE_CLASSIFIER_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SSC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SSC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/ssc_pkg.sv
`default_nettype none

package ssc_pkg;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 7;
    localparam int DEG_W       = 6;
    localparam int EDGE_W      = 12;

    localparam logic [CFG_INDEX_W-1:0] REG_MEMBER_COUNT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_IS_SIMPLE    = 2'd1;

    localparam logic CMD_ADD      = 1'b0;
    localparam logic CMD_CLASSIFY = 1'b1;

    localparam logic [2:0] CLS_NONE    = 3'd0;
    localparam logic [2:0] CLS_CLIQUE  = 3'd1;
    localparam logic [2:0] CLS_INSTAR  = 3'd2;
    localparam logic [2:0] CLS_OUTSTAR = 3'd3;
    localparam logic [2:0] CLS_DISC    = 3'd4;

    localparam logic [DEG_W-1:0]  DEG_SAT  = 6'd63;
    localparam logic [EDGE_W-1:0] EDGE_SAT = 12'd4095;

    typedef struct packed {
        logic       command;
        logic [5:0] src_member;
        logic [5:0] dst_member;
    } request_t;

    typedef struct packed {
        logic [2:0] shape_class;
        logic [5:0] hub_member;
    } result_t;

    typedef struct packed {
        logic clear;
        logic sample;
    } peak_ctl_t;

endpackage

`default_nettype wire

### design/ssc_ram.sv
`default_nettype none

module ssc_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### design/ssc_peak.sv
`default_nettype none

module ssc_peak #(
    parameter int AW = 6
) (
    input  wire logic                        clk,
    input  wire ssc_pkg::peak_ctl_t          ctl,
    input  wire logic [AW-1:0]               index,
    input  wire logic [ssc_pkg::DEG_W-1:0]   in_deg,
    input  wire logic [ssc_pkg::DEG_W-1:0]   out_deg,
    output logic      [ssc_pkg::DEG_W-1:0]   max_in,
    output logic      [ssc_pkg::DEG_W-1:0]   max_out,
    output logic      [AW-1:0]               in_hub,
    output logic      [AW-1:0]               out_hub
);

    logic [ssc_pkg::DEG_W-1:0] max_in_reg;
    logic [ssc_pkg::DEG_W-1:0] max_out_reg;
    logic [AW-1:0]             in_hub_reg;
    logic [AW-1:0]             out_hub_reg;

    // Strict comparison keeps the lowest index among equal maxima.
    always_ff @(posedge clk)
    begin
        if (ctl.clear)
        begin
            max_in_reg  <= '0;
            max_out_reg <= '0;
            in_hub_reg  <= '0;
            out_hub_reg <= '0;
        end
        else if (ctl.sample)
        begin
            if (in_deg > max_in_reg)
            begin
                max_in_reg <= in_deg;
                in_hub_reg <= index;
            end
            if (out_deg > max_out_reg)
            begin
                max_out_reg <= out_deg;
                out_hub_reg <= index;
            end
        end
    end

    assign max_in  = max_in_reg;
    assign max_out = max_out_reg;
    assign in_hub  = in_hub_reg;
    assign out_hub = out_hub_reg;

endmodule

`default_nettype wire

### design/subgraph_shape_classifier_core.sv
// Subgraph shape classifier.
// An item is taken when start is high and busy is low. An add item names a
// directed edge; it updates the source's out-degree and the destination's
// in-degree in two memories by read, modify and write, and holds busy high
// while the EDGE_WR state writes back. It gives no result.
// A classify item scans all MAX_MEMBERS entries of both memories, one address
// a cycle, tracking the peak degrees and zeroing each entry behind the scan.
// It passes through the SCAN, TAIL and DECIDE states, and its result appears
// with done for one cycle once DECIDE is left; TAIL waits for the last read
// of the registered memory read port.
// Configuration writes are taken at any time (cfg_ready is always high) and
// must only be made while the block is idle.
// After reset the block clears both memories, one entry a cycle, holding busy
// high until every entry is cleared. The receiver cannot stall; done marks each
// result for exactly one cycle.
`default_nettype none

module subgraph_shape_classifier_core #(
    parameter int MAX_MEMBERS = 64
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 start,
    output logic                                      busy,
    input  wire ssc_pkg::request_t                    request,
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [ssc_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  wire logic [ssc_pkg::CFG_DATA_W-1:0]       cfg_data,
    output logic                                      done,
    output ssc_pkg::result_t                          result
);

    localparam int AW = $clog2(MAX_MEMBERS);
    localparam int NW = $clog2(MAX_MEMBERS + 1);
    localparam int WW = NW + 7;
    localparam int BW = 2 * NW;
    localparam int DW = ssc_pkg::DEG_W;

    typedef enum logic [2:0] {
        CLEAR,
        IDLE,
        EDGE_WR,
        SCAN,
        TAIL,
        DECIDE
    } state_t;

    state_t                   state_reg, state_next;
    logic                     busy_reg, busy_next;
    logic [AW-1:0]            idx_reg, idx_next;
    logic                     rd_valid_reg, rd_valid_next;
    logic [AW-1:0]            rd_idx_reg, rd_idx_next;
    logic [AW-1:0]            src_reg, src_next;
    logic [AW-1:0]            dst_reg, dst_next;
    logic                     edge_ok_reg, edge_ok_next;
    logic [BW-1:0]            bound_reg, bound_next;
    logic [ssc_pkg::EDGE_W-1:0] edge_total_reg, edge_total_next;
    logic                     done_reg, done_next;
    ssc_pkg::result_t         result_reg, result_next;
    logic [ssc_pkg::CFG_DATA_W-1:0] member_count_reg;
    logic                     is_simple_reg;

    logic                     accept;
    logic [WW-1:0]            mc_w;
    logic [WW-1:0]            n_w;
    logic [NW-1:0]            n;
    logic [AW+5:0]            src_w;
    logic [AW+5:0]            dst_w;
    logic                     src_in;
    logic                     dst_in;
    logic [BW-1:0]            prod;

    logic                     ram_we;
    logic [AW-1:0]            out_waddr, in_waddr;
    logic [AW-1:0]            out_raddr, in_raddr;
    logic [DW-1:0]            out_wdata, in_wdata;
    logic [DW-1:0]            out_rdata, in_rdata;

    ssc_pkg::peak_ctl_t       peak_ctl;
    logic [DW-1:0]            max_in, max_out, max_m;
    logic [AW-1:0]            in_hub, out_hub, hub_sel;
    logic [AW+5:0]            hub_w;
    logic                     last_idx;

    assign accept    = start && !busy_reg;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        mc_w = WW'(member_count_reg);
        if (mc_w == '0)
        begin
            n_w = WW'(1);
        end
        else if (mc_w > WW'(MAX_MEMBERS))
        begin
            n_w = WW'(MAX_MEMBERS);
        end
        else
        begin
            n_w = mc_w;
        end
        n = n_w[NW-1:0];
    end

    assign src_w  = (AW + 6)'(request.src_member);
    assign dst_w  = (AW + 6)'(request.dst_member);
    assign src_in = WW'(request.src_member) < WW'(n);
    assign dst_in = WW'(request.dst_member) < WW'(n);
    assign prod   = BW'(n) * BW'(n - NW'(1));

    assign last_idx = (idx_reg == AW'(MAX_MEMBERS - 1));

    assign peak_ctl.clear  = accept && (request.command == ssc_pkg::CMD_CLASSIFY);
    assign peak_ctl.sample = rd_valid_reg && (WW'(rd_idx_reg) < WW'(n));

    always_comb
    begin
        ram_we    = 1'b0;
        out_waddr = rd_idx_reg;
        in_waddr  = rd_idx_reg;
        out_wdata = '0;
        in_wdata  = '0;
        out_raddr = idx_reg;
        in_raddr  = idx_reg;
        unique case (state_reg)
            CLEAR:
            begin
                ram_we    = 1'b1;
                out_waddr = idx_reg;
                in_waddr  = idx_reg;
            end
            IDLE:
            begin
                out_raddr = src_w[AW-1:0];
                in_raddr  = dst_w[AW-1:0];
            end
            EDGE_WR:
            begin
                ram_we    = edge_ok_reg;
                out_waddr = src_reg;
                in_waddr  = dst_reg;
                out_wdata = (out_rdata < ssc_pkg::DEG_SAT) ? out_rdata + DW'(1) : out_rdata;
                in_wdata  = (in_rdata < ssc_pkg::DEG_SAT) ? in_rdata + DW'(1) : in_rdata;
            end
            SCAN, TAIL:
            begin
                ram_we = rd_valid_reg;
            end
            DECIDE:
            begin
                ram_we = 1'b0;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        max_m = (max_in > max_out) ? max_in : max_out;
        if (is_simple_reg)
        begin
            result_next.shape_class = ssc_pkg::CLS_NONE;
            hub_sel                 = '0;
        end
        else if ((BW + 12)'(edge_total_reg) >= (BW + 12)'(bound_reg))
        begin
            result_next.shape_class = ssc_pkg::CLS_CLIQUE;
            hub_sel                 = '0;
        end
        else if (WW'(n - NW'(1)) < (WW'(max_m) << 1))
        begin
            if (max_in > max_out)
            begin
                result_next.shape_class = ssc_pkg::CLS_INSTAR;
                hub_sel                 = in_hub;
            end
            else
            begin
                result_next.shape_class = ssc_pkg::CLS_OUTSTAR;
                hub_sel                 = out_hub;
            end
        end
        else
        begin
            result_next.shape_class = ssc_pkg::CLS_DISC;
            hub_sel                 = '0;
        end
        hub_w                  = (AW + 6)'(hub_sel);
        result_next.hub_member = hub_w[5:0];
    end

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        rd_valid_next   = 1'b0;
        rd_idx_next     = idx_reg;
        src_next        = src_reg;
        dst_next        = dst_reg;
        edge_ok_next    = edge_ok_reg;
        bound_next      = bound_reg;
        edge_total_next = edge_total_reg;
        done_next       = 1'b0;
        unique case (state_reg)
            CLEAR:
            begin
                idx_next = idx_reg + AW'(1);
                if (last_idx)
                begin
                    idx_next   = '0;
                    state_next = IDLE;
                end
            end
            IDLE:
            begin
                if (accept)
                begin
                    if (request.command == ssc_pkg::CMD_ADD)
                    begin
                        src_next     = src_w[AW-1:0];
                        dst_next     = dst_w[AW-1:0];
                        edge_ok_next = src_in && dst_in
                                       && (request.src_member != request.dst_member);
                        state_next   = EDGE_WR;
                    end
                    else
                    begin
                        bound_next = prod >> 1;
                        idx_next   = '0;
                        state_next = SCAN;
                    end
                end
            end
            EDGE_WR:
            begin
                if (edge_ok_reg && (edge_total_reg < ssc_pkg::EDGE_SAT))
                begin
                    edge_total_next = edge_total_reg + ssc_pkg::EDGE_W'(1);
                end
                state_next = IDLE;
            end
            SCAN:
            begin
                rd_valid_next = 1'b1;
                idx_next      = idx_reg + AW'(1);
                if (last_idx)
                begin
                    idx_next   = '0;
                    state_next = TAIL;
                end
            end
            TAIL:
            begin
                state_next = DECIDE;
            end
            DECIDE:
            begin
                edge_total_next = '0;
                done_next       = 1'b1;
                state_next      = IDLE;
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
        busy_next = (state_next != IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= CLEAR;
            busy_reg       <= 1'b1;
            idx_reg        <= '0;
            rd_valid_reg   <= 1'b0;
            rd_idx_reg     <= '0;
            src_reg        <= '0;
            dst_reg        <= '0;
            edge_ok_reg    <= 1'b0;
            bound_reg      <= '0;
            edge_total_reg <= '0;
            done_reg       <= 1'b0;
            result_reg     <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            busy_reg       <= busy_next;
            idx_reg        <= idx_next;
            rd_valid_reg   <= rd_valid_next;
            rd_idx_reg     <= rd_idx_next;
            src_reg        <= src_next;
            dst_reg        <= dst_next;
            edge_ok_reg    <= edge_ok_next;
            bound_reg      <= bound_next;
            edge_total_reg <= edge_total_next;
            done_reg       <= done_next;
            if (state_reg == DECIDE)
            begin
                result_reg <= result_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            member_count_reg <= ssc_pkg::CFG_DATA_W'(1);
            is_simple_reg    <= 1'b0;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == ssc_pkg::REG_MEMBER_COUNT)
            begin
                member_count_reg <= cfg_data;
            end
            else if (cfg_index == ssc_pkg::REG_IS_SIMPLE)
            begin
                is_simple_reg <= cfg_data[0];
            end
        end
    end

    ssc_ram #(
        .WIDTH (DW),
        .DEPTH (MAX_MEMBERS)
    ) u_out_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (out_waddr),
        .wdata (out_wdata),
        .raddr (out_raddr),
        .rdata (out_rdata)
    );

    ssc_ram #(
        .WIDTH (DW),
        .DEPTH (MAX_MEMBERS)
    ) u_in_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (in_waddr),
        .wdata (in_wdata),
        .raddr (in_raddr),
        .rdata (in_rdata)
    );

    ssc_peak #(
        .AW (AW)
    ) u_peak (
        .clk     (clk),
        .ctl     (peak_ctl),
        .index   (rd_idx_reg),
        .in_deg  (in_rdata),
        .out_deg (out_rdata),
        .max_in  (max_in),
        .max_out (max_out),
        .in_hub  (in_hub),
        .out_hub (out_hub)
    );

    assign busy   = busy_reg;
    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

### design/ssc_checker.sv
`default_nettype none

`include "subgraph_shape_classifier_core_macros.svh"

module ssc_checker (
    input wire logic                             clk,
    input wire logic                             rst_n,
    input wire logic                             start,
    input wire logic                             busy,
    input wire ssc_pkg::request_t                request,
    input wire logic                             cfg_valid,
    input wire logic                             cfg_ready,
    input wire logic [ssc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input wire logic [ssc_pkg::CFG_DATA_W-1:0]   cfg_data,
    input wire logic                             done,
    input wire ssc_pkg::result_t                 result
);

    // A hub is only reported for the two star shapes.
    `SSC_ASSERT_SAME(a_hub_only_star, done, (result.shape_class == ssc_pkg::CLS_INSTAR) || (result.shape_class == ssc_pkg::CLS_OUTSTAR) || (result.hub_member == 6'd0), "hub reported for a shape that is not a star")

    `SSC_ASSERT_NEXT(a_busy_after_accept, start && !busy, busy, "block not busy after taking an item")

    `SSC_ASSERT_NEXT(a_done_single, done, !done, "result shown for more than one cycle")

    `SSC_ASSERT_SAME(a_done_after_work, done, $past(busy) && !busy, "result without a finished classify item")

endmodule

bind subgraph_shape_classifier_core ssc_checker u_ssc_checker (.*);

`default_nettype wire
